// File: design/zfe_pkg.sv
// Shared constants for the 1x2 zero-forcing equalizer.
package zfe_pkg;

   localparam int SAMPLE_WIDTH_DEF = 16;

   // Configuration register indexes.
   localparam logic [1:0] CSR_NOISE_VAR_RX0 = 2'd0;
   localparam logic [1:0] CSR_NOISE_VAR_RX1 = 2'd1;
   localparam logic [1:0] CSR_TX_SCALE      = 2'd2;

   localparam int CSR_DATA_WIDTH = 32;
   localparam int NOISE_WIDTH    = 32;
   localparam int SCALE_WIDTH    = 16;
   localparam int EQ_WIDTH       = 16;

   localparam logic [SCALE_WIDTH-1:0] TX_SCALE_RST = 16'd4096;

   // Symbol is N * 2^24 / G.
   localparam int SYM_SHIFT = 24;

   localparam logic [EQ_WIDTH-1:0]    EQ_POS_MAX = 16'h7FFF;
   localparam logic [EQ_WIDTH-1:0]    EQ_NEG_MIN = 16'h8000;
   localparam logic [NOISE_WIDTH-1:0] NOISE_MAX  = 32'hFFFF_FFFF;

endpackage

// File: design/zero_forcing_equalizer_1x2_top.sv
// Top level of the 1x2 zero-forcing equalizer with maximum-ratio combining.
//
// Usage:
//   Input channel req_*: one resource element per item, two received samples and two
//   channel estimates, signed Q1.(SAMPLE_WIDTH-1). Result channel rsp_*: equalized
//   symbol (Q4.12, saturated), post-equalization noise variance (Q16.16, saturated)
//   and zero_gain, set when the combined gain is zero (all other outputs zero).
//   Configuration port csr_*: write noise_var_rx0 (0), noise_var_rx1 (1), tx_scale (2)
//   while the block is idle; writes to index 3 are ignored.
//   Throughput: one item per cycle unless rsp_ready is held low with a result pending.
//   The pipeline is 6 multiply/add stages, 32 long-division stages (one quotient
//   bit per stage for the noise variance, the first 16 of them also dividing the
//   symbol), and the output register; the 32 division stages make up most of the depth.
//   Reset clears all valid bits and loads the register reset values
//   (noise variances 0, tx_scale 4096). When the receiver holds rsp_ready low
//   with a result pending, the whole pipeline holds and req_ready drops; no item is
//   lost or repeated.
module zero_forcing_equalizer_1x2_top
   import zfe_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0]   req_rx0_re,
   input  logic signed [SAMPLE_WIDTH-1:0]   req_rx0_im,
   input  logic signed [SAMPLE_WIDTH-1:0]   req_rx1_re,
   input  logic signed [SAMPLE_WIDTH-1:0]   req_rx1_im,
   input  logic signed [SAMPLE_WIDTH-1:0]   req_ch0_re,
   input  logic signed [SAMPLE_WIDTH-1:0]   req_ch0_im,
   input  logic signed [SAMPLE_WIDTH-1:0]   req_ch1_re,
   input  logic signed [SAMPLE_WIDTH-1:0]   req_ch1_im,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [EQ_WIDTH-1:0]       rsp_eq_re,
   output logic signed [EQ_WIDTH-1:0]       rsp_eq_im,
   output logic        [NOISE_WIDTH-1:0]    rsp_eq_noise_var,
   output logic                             rsp_zero_gain,
   input  logic                             csr_we,
   input  logic        [1:0]                csr_addr,
   input  logic        [CSR_DATA_WIDTH-1:0] csr_wdata
);

   localparam int W     = SAMPLE_WIDTH;
   localparam int PW    = 2 * W;            // one product / one squared magnitude
   localparam int NW    = 2 * W + 2;        // signed combined numerator
   localparam int NMW   = 2 * W + 1;        // numerator magnitude
   localparam int SSW   = 2 * W + 1;        // |h0|^2 + |h1|^2
   localparam int GW    = 2 * W + 16;       // gain
   localparam int HGW   = (GW + 1) / 2;     // low half of gain
   localparam int UGW   = GW - HGW;         // high half of gain
   localparam int G2W   = 2 * GW;           // gain squared
   localparam int MPW   = W + NOISE_WIDTH;  // one partial of |h|^2 * noise
   localparam int MW    = 2 * W + 33;       // weighted noise sum
   localparam int SH    = 2 * (W - 1) + 16;
   localparam int BW    = MW + SH;          // noise dividend
   localparam int AW    = GW + 10;          // symbol dividend
   localparam int NQ    = NOISE_WIDTH;      // noise quotient bits
   localparam int SQ    = EQ_WIDTH;         // symbol quotient bits
   localparam int NST   = NQ;               // division stages
   localparam int ARW   = AW - SQ;          // symbol initial remainder width
   localparam int BRW   = BW - NQ;          // noise initial remainder width

   logic en;

   // Configuration registers.
   logic [NOISE_WIDTH-1:0] nv0_ff, nv1_ff;
   logic [SCALE_WIDTH-1:0] tx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         nv0_ff <= '0;
         nv1_ff <= '0;
         tx_ff  <= TX_SCALE_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_NOISE_VAR_RX0: nv0_ff <= csr_wdata[NOISE_WIDTH-1:0];
            CSR_NOISE_VAR_RX1: nv1_ff <= csr_wdata[NOISE_WIDTH-1:0];
            CSR_TX_SCALE:      tx_ff  <= csr_wdata[SCALE_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // Stage 1: products.
   logic                 v1_ff;
   logic signed [PW-1:0] prod_ff [12];

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (en) v1_ff <= req_valid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff[0]  <= req_rx0_re * req_ch0_re;
         prod_ff[1]  <= req_rx0_im * req_ch0_im;
         prod_ff[2]  <= req_rx1_re * req_ch1_re;
         prod_ff[3]  <= req_rx1_im * req_ch1_im;
         prod_ff[4]  <= req_rx0_im * req_ch0_re;
         prod_ff[5]  <= req_rx0_re * req_ch0_im;
         prod_ff[6]  <= req_rx1_im * req_ch1_re;
         prod_ff[7]  <= req_rx1_re * req_ch1_im;
         prod_ff[8]  <= req_ch0_re * req_ch0_re;
         prod_ff[9]  <= req_ch0_im * req_ch0_im;
         prod_ff[10] <= req_ch1_re * req_ch1_re;
         prod_ff[11] <= req_ch1_im * req_ch1_im;
      end
   end

   // Stage 2: sums.
   logic                 v2_ff;
   logic signed [NW-1:0] nr_ff, ni_ff;
   logic [PW-1:0]        s0_ff, s1_ff;
   logic [SSW-1:0]       s_ff;
   logic [PW-1:0]        s0_in, s1_in;

   assign s0_in = prod_ff[8] + prod_ff[9];
   assign s1_in = prod_ff[10] + prod_ff[11];

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (en) v2_ff <= v1_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nr_ff <= NW'(prod_ff[0]) + NW'(prod_ff[1]) + NW'(prod_ff[2]) + NW'(prod_ff[3]);
         ni_ff <= NW'(prod_ff[4]) - NW'(prod_ff[5]) + NW'(prod_ff[6]) - NW'(prod_ff[7]);
         s0_ff <= s0_in;
         s1_ff <= s1_in;
         s_ff  <= SSW'(s0_in) + SSW'(s1_in);
      end
   end

   // Stage 3: gain, noise partials, numerator magnitudes.
   logic            v3_ff;
   logic [GW-1:0]   g3_ff;
   logic [MPW-1:0]  m0l_ff, m0h_ff, m1l_ff, m1h_ff;
   logic [NMW-1:0]  mre3_ff, mim3_ff;
   logic            nre3_ff, nim3_ff;
   logic [NMW-1:0]  absr_in, absi_in;

   assign absr_in = nr_ff[NW-1] ? NMW'(-nr_ff) : NMW'(nr_ff);
   assign absi_in = ni_ff[NW-1] ? NMW'(-ni_ff) : NMW'(ni_ff);

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (en) v3_ff <= v2_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         g3_ff   <= GW'(tx_ff * s_ff);
         m0l_ff  <= MPW'(s0_ff[W-1:0]  * nv0_ff);
         m0h_ff  <= MPW'(s0_ff[PW-1:W] * nv0_ff);
         m1l_ff  <= MPW'(s1_ff[W-1:0]  * nv1_ff);
         m1h_ff  <= MPW'(s1_ff[PW-1:W] * nv1_ff);
         mre3_ff <= absr_in;
         mim3_ff <= absi_in;
         nre3_ff <= nr_ff[NW-1];
         nim3_ff <= ni_ff[NW-1];
      end
   end

   // Stage 4: noise sum, gain-squared partials.
   logic                 v4_ff;
   logic [MW-1:0]        m4_ff;
   logic [GW-1:0]        g4_ff;
   logic [2*HGW-1:0]     gll_ff;
   logic [HGW+UGW-1:0]   glh_ff;
   logic [2*UGW-1:0]     ghh_ff;
   logic [NMW-1:0]       mre4_ff, mim4_ff;
   logic                 nre4_ff, nim4_ff;

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (en) v4_ff <= v3_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m4_ff   <= (MW'(m0h_ff) << W) + MW'(m0l_ff) + (MW'(m1h_ff) << W) + MW'(m1l_ff);
         g4_ff   <= g3_ff;
         gll_ff  <= g3_ff[HGW-1:0] * g3_ff[HGW-1:0];
         glh_ff  <= g3_ff[HGW-1:0] * g3_ff[GW-1:HGW];
         ghh_ff  <= g3_ff[GW-1:HGW] * g3_ff[GW-1:HGW];
         mre4_ff <= mre3_ff;
         mim4_ff <= mim3_ff;
         nre4_ff <= nre3_ff;
         nim4_ff <= nim3_ff;
      end
   end

   // Stage 5: gain squared, symbol dividends.
   logic            v5_ff;
   logic [MW-1:0]   m5_ff;
   logic [GW-1:0]   g5_ff;
   logic [G2W-1:0]  g2_5_ff;
   logic [AW-1:0]   are_ff, aim_ff;
   logic            nre5_ff, nim5_ff;

   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else if (en) v5_ff <= v4_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m5_ff   <= m4_ff;
         g5_ff   <= g4_ff;
         g2_5_ff <= (G2W'(ghh_ff) << (2 * HGW)) + (G2W'(glh_ff) << (HGW + 1))
                    + G2W'(gll_ff);
         are_ff  <= (AW'(mre4_ff) << SYM_SHIFT) + AW'(g4_ff >> 1);
         aim_ff  <= (AW'(mim4_ff) << SYM_SHIFT) + AW'(g4_ff >> 1);
         nre5_ff <= nre4_ff;
         nim5_ff <= nim4_ff;
      end
   end

   // Stage 6 (division stage 0) inputs: noise dividend and overflow checks.
   logic [BW-1:0] b_in;
   assign b_in = (BW'(m5_ff) << SH) + BW'(g2_5_ff >> 1);

   // Division pipeline, one quotient bit per stage.
   logic            dv_ff   [0:NST];
   logic [G2W-1:0]  dg2_ff  [0:NST];
   logic [GW-1:0]   dg_ff   [0:NST];
   logic [G2W-1:0]  nrem_ff [0:NST];
   logic [NQ-1:0]   nlow_ff [0:NST];
   logic [NQ-1:0]   nq_ff   [0:NST];
   logic            novf_ff [0:NST];
   logic [GW-1:0]   rrem_ff [0:NST];
   logic [SQ-1:0]   rlow_ff [0:NST];
   logic [SQ-1:0]   rq_ff   [0:NST];
   logic            rovf_ff [0:NST];
   logic            rneg_ff [0:NST];
   logic [GW-1:0]   irem_ff [0:NST];
   logic [SQ-1:0]   ilow_ff [0:NST];
   logic [SQ-1:0]   iq_ff   [0:NST];
   logic            iovf_ff [0:NST];
   logic            ineg_ff [0:NST];

   genvar gi;
   generate
      for (gi = 0; gi <= NST; gi++) begin : g_div
         if (gi == 0) begin : g_init
            always_ff @(posedge clock) begin
               if (reset) dv_ff[0] <= 1'b0;
               else if (en) dv_ff[0] <= v5_ff;
            end
            always_ff @(posedge clock) begin
               if (en) begin
                  dg2_ff[0]  <= g2_5_ff;
                  dg_ff[0]   <= g5_ff;
                  nrem_ff[0] <= G2W'(b_in[BW-1:NQ]);
                  nlow_ff[0] <= b_in[NQ-1:0];
                  nq_ff[0]   <= '0;
                  novf_ff[0] <= G2W'(b_in[BW-1:NQ]) >= g2_5_ff;
                  rrem_ff[0] <= GW'(are_ff[AW-1:SQ]);
                  rlow_ff[0] <= are_ff[SQ-1:0];
                  rq_ff[0]   <= '0;
                  rovf_ff[0] <= GW'(are_ff[AW-1:SQ]) >= g5_ff;
                  rneg_ff[0] <= nre5_ff;
                  irem_ff[0] <= GW'(aim_ff[AW-1:SQ]);
                  ilow_ff[0] <= aim_ff[SQ-1:0];
                  iq_ff[0]   <= '0;
                  iovf_ff[0] <= GW'(aim_ff[AW-1:SQ]) >= g5_ff;
                  ineg_ff[0] <= nim5_ff;
               end
            end
         end else begin : g_step
            localparam int K = gi - 1;
            logic [G2W:0] ntry;

            assign ntry = {nrem_ff[K], nlow_ff[K][NQ-1-K]};

            always_ff @(posedge clock) begin
               if (reset) dv_ff[gi] <= 1'b0;
               else if (en) dv_ff[gi] <= dv_ff[K];
            end

            always_ff @(posedge clock) begin
               if (en) begin
                  dg2_ff[gi]  <= dg2_ff[K];
                  dg_ff[gi]   <= dg_ff[K];
                  nlow_ff[gi] <= nlow_ff[K];
                  novf_ff[gi] <= novf_ff[K];
                  rlow_ff[gi] <= rlow_ff[K];
                  rovf_ff[gi] <= rovf_ff[K];
                  rneg_ff[gi] <= rneg_ff[K];
                  ilow_ff[gi] <= ilow_ff[K];
                  iovf_ff[gi] <= iovf_ff[K];
                  ineg_ff[gi] <= ineg_ff[K];
                  if (ntry >= {1'b0, dg2_ff[K]}) begin
                     nrem_ff[gi] <= G2W'(ntry - {1'b0, dg2_ff[K]});
                     nq_ff[gi]   <= nq_ff[K] | (NQ'(1) << (NQ - 1 - K));
                  end else begin
                     nrem_ff[gi] <= ntry[G2W-1:0];
                     nq_ff[gi]   <= nq_ff[K];
                  end
               end
            end

            if (K < SQ) begin : g_sym
               logic [GW:0] rtry, itry;

               assign rtry = {rrem_ff[K], rlow_ff[K][SQ-1-K]};
               assign itry = {irem_ff[K], ilow_ff[K][SQ-1-K]};
               always_ff @(posedge clock) begin
                  if (en) begin
                     if (rtry >= {1'b0, dg_ff[K]}) begin
                        rrem_ff[gi] <= GW'(rtry - {1'b0, dg_ff[K]});
                        rq_ff[gi]   <= rq_ff[K] | (SQ'(1) << (SQ - 1 - K));
                     end else begin
                        rrem_ff[gi] <= rtry[GW-1:0];
                        rq_ff[gi]   <= rq_ff[K];
                     end
                     if (itry >= {1'b0, dg_ff[K]}) begin
                        irem_ff[gi] <= GW'(itry - {1'b0, dg_ff[K]});
                        iq_ff[gi]   <= iq_ff[K] | (SQ'(1) << (SQ - 1 - K));
                     end else begin
                        irem_ff[gi] <= itry[GW-1:0];
                        iq_ff[gi]   <= iq_ff[K];
                     end
                  end
               end
            end else begin : g_hold
               always_ff @(posedge clock) begin
                  if (en) begin
                     rrem_ff[gi] <= rrem_ff[K];
                     rq_ff[gi]   <= rq_ff[K];
                     irem_ff[gi] <= irem_ff[K];
                     iq_ff[gi]   <= iq_ff[K];
                  end
               end
            end
         end
      end
   endgenerate

   // Output stage: saturate, apply sign, force zero on zero gain.
   logic                  zero_in;
   logic [EQ_WIDTH-1:0]   re_in, im_in;
   logic [NOISE_WIDTH-1:0] nv_in;
   logic                  ovld_ff;
   logic [EQ_WIDTH-1:0]   ore_ff, oim_ff;
   logic [NOISE_WIDTH-1:0] onv_ff;
   logic                  ozero_ff;

   assign zero_in = (dg_ff[NST] == '0);

   always_comb begin
      if (rneg_ff[NST]) begin
         if (rovf_ff[NST] || rq_ff[NST] >= EQ_NEG_MIN) re_in = EQ_NEG_MIN;
         else re_in = EQ_WIDTH'(-rq_ff[NST]);
      end else begin
         if (rovf_ff[NST] || rq_ff[NST] > EQ_POS_MAX) re_in = EQ_POS_MAX;
         else re_in = rq_ff[NST];
      end
      if (ineg_ff[NST]) begin
         if (iovf_ff[NST] || iq_ff[NST] >= EQ_NEG_MIN) im_in = EQ_NEG_MIN;
         else im_in = EQ_WIDTH'(-iq_ff[NST]);
      end else begin
         if (iovf_ff[NST] || iq_ff[NST] > EQ_POS_MAX) im_in = EQ_POS_MAX;
         else im_in = iq_ff[NST];
      end
      nv_in = novf_ff[NST] ? NOISE_MAX : nq_ff[NST];
      if (zero_in) begin
         re_in = '0;
         im_in = '0;
         nv_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) ovld_ff <= 1'b0;
      else if (en) ovld_ff <= dv_ff[NST];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ore_ff   <= re_in;
         oim_ff   <= im_in;
         onv_ff   <= nv_in;
         ozero_ff <= zero_in;
      end
   end

   assign rsp_valid        = ovld_ff;
   assign rsp_eq_re        = ore_ff;
   assign rsp_eq_im        = oim_ff;
   assign rsp_eq_noise_var = onv_ff;
   assign rsp_zero_gain    = ozero_ff;

endmodule
